// ===== hdl/mi3_pkg.sv =====
// shared types, widths and the cofactor index table for the 3x3 matrix inverse
package mi3_pkg;

   localparam int ELEM_W   = 32;                 // Q16.16 element
   localparam int FRAC_W   = 32;                 // numerator shift, adj * 2^32
   localparam int PROD_W   = 2 * ELEM_W;         // element product
   localparam int COF_W    = PROD_W + 1;         // cofactor, signed
   localparam int LO_W     = COF_W - ELEM_W;     // low part of a split cofactor
   localparam int PL_W     = LO_W + 1 + ELEM_W;  // low partial product, signed
   localparam int DET_W    = COF_W + ELEM_W + 2; // determinant, signed
   localparam int NUM_W    = COF_W + FRAC_W;     // numerator magnitude
   localparam int DSH_W    = DET_W + FRAC_W;     // shifted divisor
   localparam int QUO_W    = FRAC_W + 1;         // quotient bits kept
   localparam int CNT_W    = $clog2(QUO_W);
   localparam int N_ELEM   = 9;
   localparam int N_PROD   = 2 * N_ELEM;
   localparam int FRONT_STAGES = 6;
   localparam int QUEUE_DEPTH  = 2;

   // operands of each cofactor: e[a]*e[b] - e[c]*e[d]
   localparam int COF_TERMS [N_ELEM][4] = '{
      '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   // one classified matrix waiting for division
   typedef struct packed {
      logic                              zero;
      logic [N_ELEM-1:0]                 neg;
      logic [DET_W-1:0]                  dabs;
      logic [N_ELEM-1:0][COF_W-1:0]      cmag;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DONE
   } back_state_type;

endpackage

// ===== hdl/mi3_front.sv =====
// front pipeline: cofactors, determinant, signs and magnitudes
module mi3_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] in_elem,
   output logic                                      in_stall,
   output logic                                      push,
   output mi3_pkg::entry_type                        push_entry,
   input  logic                                      queue_full
);

   logic [mi3_pkg::FRONT_STAGES-1:0] v_ff;
   logic adv;

   logic signed [mi3_pkg::PROD_W-1:0] p_ff [mi3_pkg::N_PROD];
   logic signed [mi3_pkg::ELEM_W-1:0] e1_ff [3];
   logic signed [mi3_pkg::ELEM_W-1:0] e2_ff [3];
   logic signed [mi3_pkg::COF_W-1:0]  c2_ff [mi3_pkg::N_ELEM];
   logic signed [mi3_pkg::COF_W-1:0]  c3_ff [mi3_pkg::N_ELEM];
   logic signed [mi3_pkg::COF_W-1:0]  c4_ff [mi3_pkg::N_ELEM];
   logic signed [mi3_pkg::COF_W-1:0]  c5_ff [mi3_pkg::N_ELEM];
   logic signed [mi3_pkg::PROD_W-1:0] ph_ff [3];
   logic signed [mi3_pkg::PL_W-1:0]   pl_ff [3];
   logic signed [mi3_pkg::DET_W-1:0]  t_ff [3];
   logic signed [mi3_pkg::DET_W-1:0]  det_ff;
   mi3_pkg::entry_type                out_ff;

   assign adv        = !(v_ff[mi3_pkg::FRONT_STAGES-1] && queue_full);
   assign in_stall   = !adv;
   assign push       = v_ff[mi3_pkg::FRONT_STAGES-1] && !queue_full;
   assign push_entry = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[mi3_pkg::FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: the eighteen element products
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            p_ff[2*i] <=
               mi3_pkg::PROD_W'($signed(in_elem[mi3_pkg::COF_TERMS[i][0]])) *
               mi3_pkg::PROD_W'($signed(in_elem[mi3_pkg::COF_TERMS[i][1]]));
            p_ff[2*i+1] <=
               mi3_pkg::PROD_W'($signed(in_elem[mi3_pkg::COF_TERMS[i][2]])) *
               mi3_pkg::PROD_W'($signed(in_elem[mi3_pkg::COF_TERMS[i][3]]));
         end
         for (int j = 0; j < 3; j++) begin
            e1_ff[j] <= $signed(in_elem[j]);
            e2_ff[j] <= e1_ff[j];
         end
         // stage 2: cofactors
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            c2_ff[i] <= mi3_pkg::COF_W'(p_ff[2*i]) - mi3_pkg::COF_W'(p_ff[2*i+1]);
            c3_ff[i] <= c2_ff[i];
            c4_ff[i] <= c3_ff[i];
            c5_ff[i] <= c4_ff[i];
         end
         // stage 3: first-row cofactors times first-row elements, split in two
         for (int j = 0; j < 3; j++) begin
            ph_ff[j] <= mi3_pkg::PROD_W'($signed(c2_ff[3*j][mi3_pkg::COF_W-1:mi3_pkg::LO_W])) *
                        mi3_pkg::PROD_W'(e2_ff[j]);
            pl_ff[j] <= mi3_pkg::PL_W'($signed({1'b0, c2_ff[3*j][mi3_pkg::LO_W-1:0]})) *
                        mi3_pkg::PL_W'(e2_ff[j]);
         end
         // stage 4: recombine the halves
         for (int j = 0; j < 3; j++) begin
            t_ff[j] <= (mi3_pkg::DET_W'(ph_ff[j]) <<< mi3_pkg::LO_W) +
                       mi3_pkg::DET_W'(pl_ff[j]);
         end
         // stage 5: determinant
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
         // stage 6: classify
         out_ff.zero <= (det_ff == '0);
         out_ff.dabs <= det_ff[mi3_pkg::DET_W-1] ? -det_ff : det_ff;
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            out_ff.neg[i]  <= c5_ff[i][mi3_pkg::COF_W-1] ^ det_ff[mi3_pkg::DET_W-1];
            out_ff.cmag[i] <= c5_ff[i][mi3_pkg::COF_W-1] ? -c5_ff[i] : c5_ff[i];
         end
      end
   end

endmodule

// ===== hdl/mi3_queue.sv =====
// short queue of classified matrices between front and back
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mi3_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output mi3_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mi3_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/mi3_back.sv =====
// back end: nine bit-serial dividers, saturation and the result register
module mi3_back (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_not_empty,
   input  mi3_pkg::entry_type                         q_entry,
   output logic                                       q_pop,
   output logic                                       out_valid,
   input  logic                                       out_stall,
   output logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] out_elem,
   output logic                                       out_singular,
   output logic                                       out_overflowed
);

   mi3_pkg::back_state_type state_ff, state_in;

   logic [mi3_pkg::CNT_W-1:0] cnt_ff;
   logic [mi3_pkg::DSH_W-1:0] dsh_ff;
   logic [mi3_pkg::NUM_W-1:0] rem_ff [mi3_pkg::N_ELEM];
   logic [mi3_pkg::QUO_W-1:0] quo_ff [mi3_pkg::N_ELEM];
   logic [mi3_pkg::N_ELEM-1:0] neg_ff;
   logic zero_ff;

   logic out_valid_ff;
   logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] out_elem_ff;
   logic out_singular_ff, out_overflowed_ff;

   logic out_free, load, step, store;
   logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] res;
   logic [mi3_pkg::N_ELEM-1:0] sat;

   assign out_free       = !out_valid_ff || !out_stall;
   assign out_valid      = out_valid_ff;
   assign out_elem       = out_elem_ff;
   assign out_singular   = out_singular_ff;
   assign out_overflowed = out_overflowed_ff;
   assign q_pop          = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mi3_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      step     = 1'b0;
      store    = 1'b0;
      case (state_ff)
         mi3_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               load     = 1'b1;
               state_in = mi3_pkg::BK_RUN;
            end
         end
         mi3_pkg::BK_RUN: begin
            step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = mi3_pkg::BK_DONE;
            end
         end
         mi3_pkg::BK_DONE: begin
            if (out_free) begin
               store    = 1'b1;
               state_in = mi3_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mi3_pkg::BK_IDLE;
         end
      endcase
   end

   // one quotient bit per cycle in every lane, divisor shared
   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff  <= mi3_pkg::CNT_W'(mi3_pkg::QUO_W - 1);
         dsh_ff  <= {q_entry.dabs, {mi3_pkg::FRAC_W{1'b0}}};
         neg_ff  <= q_entry.neg;
         zero_ff <= q_entry.zero;
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            rem_ff[i] <= {q_entry.cmag[i], {mi3_pkg::FRAC_W{1'b0}}};
            quo_ff[i] <= '0;
         end
      end else if (step) begin
         cnt_ff <= cnt_ff - 1'b1;
         dsh_ff <= dsh_ff >> 1;
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            if (mi3_pkg::DSH_W'(rem_ff[i]) >= dsh_ff) begin
               rem_ff[i] <= rem_ff[i] - dsh_ff[mi3_pkg::NUM_W-1:0];
               quo_ff[i] <= {quo_ff[i][mi3_pkg::QUO_W-2:0], 1'b1};
            end else begin
               quo_ff[i] <= {quo_ff[i][mi3_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // saturate to the signed element range, limit depends on the sign
   always_comb begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
         logic [mi3_pkg::ELEM_W-1:0] limit, mag;
         limit  = neg_ff[i] ? {1'b1, {(mi3_pkg::ELEM_W-1){1'b0}}}
                            : {1'b0, {(mi3_pkg::ELEM_W-1){1'b1}}};
         sat[i] = quo_ff[i][mi3_pkg::QUO_W-1] ||
                  (quo_ff[i][mi3_pkg::ELEM_W-1:0] > limit);
         mag    = sat[i] ? limit : quo_ff[i][mi3_pkg::ELEM_W-1:0];
         res[i] = zero_ff ? '0 : (neg_ff[i] ? -mag : mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (store) begin
         out_valid_ff <= 1'b1;
      end else if (!out_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         out_elem_ff       <= res;
         out_singular_ff   <= zero_ff;
         out_overflowed_ff <= !zero_ff && (sat != '0);
      end
   end

endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate: a six-stage front pipeline forms the
// nine cofactors and the exact determinant and takes a new matrix every cycle
// while the queue has room; the back end divides all nine numerators at once,
// one quotient bit per cycle; each matrix passes through load, the quotient
// steps and store there, and the divider takes no new matrix until the last
// is stored, so it sets the sustained rate. Elements are truncated toward
// zero and saturated to Q16.16; a zero determinant gives all-zero elements
// with singular set.
module matrix3x3_inverse #(
   parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [31:0] req_m00,
   input  logic signed [31:0] req_m01,
   input  logic signed [31:0] req_m02,
   input  logic signed [31:0] req_m10,
   input  logic signed [31:0] req_m11,
   input  logic signed [31:0] req_m12,
   input  logic signed [31:0] req_m20,
   input  logic signed [31:0] req_m21,
   input  logic signed [31:0] req_m22,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_r00,
   output logic signed [31:0] rsp_r01,
   output logic signed [31:0] rsp_r02,
   output logic signed [31:0] rsp_r10,
   output logic signed [31:0] rsp_r11,
   output logic signed [31:0] rsp_r12,
   output logic signed [31:0] rsp_r20,
   output logic signed [31:0] rsp_r21,
   output logic signed [31:0] rsp_r22,
   output logic        rsp_singular,
   output logic        rsp_overflowed
);

   logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::ELEM_W-1:0] in_elem, out_elem;
   logic push, full, pop, not_empty;
   mi3_pkg::entry_type push_entry, pop_entry;

   assign in_elem = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                     req_m02, req_m01, req_m00};

   assign rsp_r00 = out_elem[0];
   assign rsp_r01 = out_elem[1];
   assign rsp_r02 = out_elem[2];
   assign rsp_r10 = out_elem[3];
   assign rsp_r11 = out_elem[4];
   assign rsp_r12 = out_elem[5];
   assign rsp_r20 = out_elem[6];
   assign rsp_r21 = out_elem[7];
   assign rsp_r22 = out_elem[8];

   mi3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_elem    (in_elem),
      .in_stall   (req_stall),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (full)
   );

   mi3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   mi3_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (not_empty),
      .q_entry        (pop_entry),
      .q_pop          (pop),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_elem       (out_elem),
      .out_singular   (rsp_singular),
      .out_overflowed (rsp_overflowed)
   );

endmodule
